/* hdl/mbet_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and constants for the escape-time pixel evaluator: controller
// states, controller-to-datapath commands, status flags and register codes.
// ----------------------------------------------------------------------------
package mbet_pkg;

	localparam int MBET_FRAC_BITS = 28;
	localparam int MBET_DIM_BITS  = 12;

	localparam int PIX_W   = 12;
	localparam int IMG_W   = 13;
	localparam int CNT_W   = 16;
	localparam int GRAY_W  = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [IMG_W-1:0] IMAGE_WIDTH_RST  = IMG_W'(1600);
	localparam logic [IMG_W-1:0] IMAGE_HEIGHT_RST = IMG_W'(1200);
	localparam logic [CNT_W-1:0] ITER_LIMIT_RST   = CNT_W'(1000);

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CR_GO,
		ST_CR_WAIT,
		ST_CI_GO,
		ST_CI_WAIT,
		ST_ADD,
		ST_MUL,
		ST_GRAY_GO,
		ST_GRAY_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		DIV_CR,
		DIV_CI,
		DIV_GRAY
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     div_start;
		div_sel_t div_sel;
		logic     store_cr;
		logic     store_ci;
		logic     store_gray;
		logic     iter_init;
		logic     iter_add;
		logic     iter_mul;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sum_escape;
		logic limit_hit;
		logic range_escape;
	} status_t;

endpackage

/* hdl/mbet_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_div
// Serial restoring divider: one quotient bit per cycle from start until the
// done pulse.
// ----------------------------------------------------------------------------
module mbet_div #(
	parameter int DIVIDEND_W = 42,
	parameter int DIVISOR_W  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [CW-1:0]         cnt_q;
	logic                  active_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic                  ge;

	assign shifted = {rem_q, num_q[DIVIDEND_W-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= CW'(DIVIDEND_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (active_q) begin
			num_q <= {num_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? DIVISOR_W'(shifted - {1'b0, den_q}) : shifted[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

/* hdl/mbet_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_datapath
// Configuration registers, coordinate mapping, the z = z^2 + c iteration
// registers with their multipliers, the iteration counter and the gray level.
// ----------------------------------------------------------------------------
module mbet_datapath
	import mbet_pkg::*;
#(
	parameter int FRAC_BITS = MBET_FRAC_BITS,
	parameter int DIM_BITS  = MBET_DIM_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic [CNT_W-1:0]     iteration_count,
	output logic [GRAY_W-1:0]    gray_level
);

	localparam int WB   = DIM_BITS + 1;
	localparam int XW   = DIM_BITS + 2;
	localparam int Y6W  = DIM_BITS + 3;
	localparam int W5W  = DIM_BITS + 4;
	localparam int H9W  = DIM_BITS + 5;
	localparam int NW   = XW + FRAC_BITS;
	localparam int GNW  = CNT_W + GRAY_W;
	localparam int DW   = (NW > GNW) ? NW : GNW;
	localparam int DVW  = (WB > CNT_W) ? WB : CNT_W;
	localparam int ZW   = FRAC_BITS + 5;
	localparam int QW   = FRAC_BITS + 3;
	localparam int MW   = FRAC_BITS + 2;
	localparam int PW   = 2 * MW;
	localparam int SQW  = PW - FRAC_BITS;

	localparam logic signed [ZW-1:0] TWO_FX     = {5'd2, {FRAC_BITS{1'b0}}};
	localparam logic signed [ZW-1:0] NEG_TWO_FX = {5'b11110, {FRAC_BITS{1'b0}}};
	localparam logic signed [ZW-1:0] THREE_FX   = {5'd3, {FRAC_BITS{1'b0}}};
	localparam logic signed [ZW-1:0] ONE_HALF_FX = {5'd1, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic [ZW-1:0]        FOUR_FX    = {5'd4, {FRAC_BITS{1'b0}}};
	localparam logic [PW-1:0]        RND_MASK   = (PW'(1) << (FRAC_BITS - 1)) - PW'(1);

	logic [IMG_W-1:0]  width_q;
	logic [IMG_W-1:0]  height_q;
	logic [CNT_W-1:0]  limit_q;
	logic [PIX_W-1:0]  x_q;
	logic [PIX_W-1:0]  y_q;

	logic [DIM_BITS-1:0] x_m;
	logic [DIM_BITS-1:0] y_m;
	logic [WB-1:0]       w_m;
	logic [WB-1:0]       h_m;
	logic [WB-1:0]       w_d;
	logic [WB-1:0]       h_d;
	logic [XW-1:0]       x3;
	logic [XW-1:0]       y3;
	logic [Y6W-1:0]      y6;
	logic [W5W-1:0]      w5;
	logic [H9W-1:0]      h9;
	logic                clamp_x;
	logic                clamp_y;

	logic [DW-1:0]  div_num;
	logic [DVW-1:0] div_den;
	logic [DW-1:0]  div_q;
	logic           div_done;
	logic [GNW-1:0] gray_num;

	logic signed [ZW-1:0] cr_q;
	logic signed [ZW-1:0] ci_q;
	logic signed [ZW-1:0] zr_q;
	logic signed [ZW-1:0] zi_q;
	logic [PW-1:0]        sq_r_q;
	logic [PW-1:0]        sq_i_q;
	logic [PW-1:0]        cross_q;
	logic                 cross_neg_q;
	logic [CNT_W-1:0]     count_q;
	logic [GRAY_W-1:0]    gray_q;

	logic [SQW-1:0]       zr2;
	logic [SQW-1:0]       zi2;
	logic [ZW-1:0]        sq_sum;
	logic [PW-1:0]        cross_rnd;
	logic [ZW-1:0]        cross_mag;
	logic signed [ZW-1:0] cross_fx;
	logic signed [ZW-1:0] zr_new;
	logic signed [ZW-1:0] zi_new;
	logic signed [ZW-1:0] zr_abs;
	logic signed [ZW-1:0] zi_abs;
	logic [MW-1:0]        mag_r;
	logic [MW-1:0]        mag_i;
	logic [QW-1:0]        coord_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_WIDTH_RST;
			height_q <= IMAGE_HEIGHT_RST;
			limit_q  <= ITER_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[IMG_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[IMG_W-1:0];
				CFG_ITER_LIMIT:   limit_q  <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q <= pixel_x;
			y_q <= pixel_y;
		end
	end

	// coordinate mapping terms
	assign x_m = DIM_BITS'(x_q);
	assign y_m = DIM_BITS'(y_q);
	assign w_m = WB'(width_q);
	assign h_m = WB'(height_q);
	assign w_d = (w_m == '0) ? WB'(1) : w_m;
	assign h_d = (h_m == '0) ? WB'(1) : h_m;
	assign x3  = XW'({x_m, 1'b0}) + XW'(x_m);
	assign y3  = XW'({y_m, 1'b0}) + XW'(y_m);
	assign y6  = {y3, 1'b0};
	assign w5  = W5W'({w_d, 2'b00}) + W5W'(w_d);
	assign h9  = H9W'({h_d, 3'b000}) + H9W'(h_d);
	assign clamp_x = W5W'(x3) >= w5;
	assign clamp_y = H9W'(y6) >= h9;

	assign gray_num = {count_q, {GRAY_W{1'b0}}} - GNW'(count_q);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_CR: begin
				div_num = DW'({x3, {FRAC_BITS{1'b0}}});
				div_den = DVW'(w_d);
			end
			DIV_CI: begin
				div_num = DW'({y3, {FRAC_BITS{1'b0}}});
				div_den = DVW'(h_d);
			end
			DIV_GRAY: begin
				div_num = DW'(gray_num);
				div_den = DVW'(limit_q);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	mbet_div #(
		.DIVIDEND_W(DW),
		.DIVISOR_W (DVW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_q)
	);

	assign coord_q = div_q[QW-1:0];

	// add step: floor the products to fixed point and form the next z
	assign zr2       = sq_r_q[PW-1:FRAC_BITS];
	assign zi2       = sq_i_q[PW-1:FRAC_BITS];
	assign sq_sum    = ZW'(zr2) + ZW'(zi2);
	assign cross_rnd = cross_neg_q ? (cross_q + RND_MASK) : cross_q;
	assign cross_mag = cross_rnd[PW-1:FRAC_BITS-1];
	assign cross_fx  = cross_neg_q ? -$signed(cross_mag) : $signed(cross_mag);
	assign zr_new    = $signed(ZW'(zr2)) - $signed(ZW'(zi2)) + cr_q;
	assign zi_new    = cross_fx + ci_q;

	// multiply step operands
	assign zr_abs = zr_q[ZW-1] ? -zr_q : zr_q;
	assign zi_abs = zi_q[ZW-1] ? -zi_q : zi_q;
	assign mag_r  = zr_abs[MW-1:0];
	assign mag_i  = zi_abs[MW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.store_cr) begin
			cr_q <= clamp_x ? THREE_FX : ($signed({2'b00, coord_q}) - TWO_FX);
		end
		if (cmd.store_ci) begin
			ci_q <= clamp_y ? THREE_FX : ($signed({2'b00, coord_q}) - ONE_HALF_FX);
		end
		if (cmd.iter_init) begin
			sq_r_q      <= '0;
			sq_i_q      <= '0;
			cross_q     <= '0;
			cross_neg_q <= 1'b0;
			count_q     <= '0;
		end else if (cmd.iter_add) begin
			zr_q    <= zr_new;
			zi_q    <= zi_new;
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.iter_mul) begin
			sq_r_q      <= PW'(mag_r) * PW'(mag_r);
			sq_i_q      <= PW'(mag_i) * PW'(mag_i);
			cross_q     <= PW'(mag_r) * PW'(mag_i);
			cross_neg_q <= zr_q[ZW-1] ^ zi_q[ZW-1];
		end
		if (cmd.store_gray) begin
			gray_q <= (count_q == limit_q) ? '0 : div_q[GRAY_W-1:0];
		end
	end

	assign status.div_done     = div_done;
	assign status.sum_escape   = sq_sum > FOUR_FX;
	assign status.limit_hit    = count_q == limit_q;
	assign status.range_escape = (zr_q > TWO_FX) || (zr_q < NEG_TWO_FX) ||
		(zi_q > TWO_FX) || (zi_q < NEG_TWO_FX);

	assign iteration_count = count_q;
	assign gray_level      = gray_q;

endmodule

/* hdl/mbet_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_ctrl
// Sequencer for one item: map column, map row, iterate, scale the count to a
// gray level, strobe the result.
// ----------------------------------------------------------------------------
module mbet_ctrl
	import mbet_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:      if (start) state_nxt = ST_CR_GO;
			ST_CR_GO:     state_nxt = ST_CR_WAIT;
			ST_CR_WAIT:   if (status.div_done) state_nxt = ST_CI_GO;
			ST_CI_GO:     state_nxt = ST_CI_WAIT;
			ST_CI_WAIT:   if (status.div_done) state_nxt = ST_ADD;
			ST_ADD: begin
				if (status.sum_escape || status.limit_hit) begin
					state_nxt = ST_GRAY_GO;
				end else begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				if (status.range_escape) begin
					state_nxt = ST_GRAY_GO;
				end else begin
					state_nxt = ST_ADD;
				end
			end
			ST_GRAY_GO:   state_nxt = ST_GRAY_WAIT;
			ST_GRAY_WAIT: if (status.div_done) state_nxt = ST_DONE;
			ST_DONE:      state_nxt = ST_IDLE;
			default:      state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = DIV_CR;
		busy        = 1'b1;
		done        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			ST_CR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_CR;
			end
			ST_CR_WAIT: cmd.store_cr = status.div_done;
			ST_CI_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_CI;
			end
			ST_CI_WAIT: begin
				cmd.store_ci  = status.div_done;
				cmd.iter_init = status.div_done;
			end
			ST_ADD: cmd.iter_add = !(status.sum_escape || status.limit_hit);
			ST_MUL: cmd.iter_mul = !status.range_escape;
			ST_GRAY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_GRAY;
			end
			ST_GRAY_WAIT: cmd.store_gray = status.div_done;
			ST_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

/* hdl/mandelbrot_escape_time_pixel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one pixel of the Mandelbrot set in fixed point.
//
// Pulse start with pixel_x/pixel_y while busy is low; the item is taken at
// that edge and busy rises. The column and row are mapped to c by a shared
// serial divider, then z = z^2 + c runs as an add step and a multiply step
// per iteration. The gray level takes one more divider pass. One item is in
// flight at a time and busy falls in the cycle after done. done is high for
// one cycle with iteration_count and gray_level; the receiver must take it
// then. cfg_write updates image_width, image_height or iteration_limit at
// once; the user must use it only while busy is low, which the block does
// not enforce. Reset returns to idle with 1600 x 1200 and limit 1000.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel
	import mbet_pkg::*;
#(
	parameter int FRAC_BITS = MBET_FRAC_BITS,
	parameter int DIM_BITS  = MBET_DIM_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	output logic                 done,
	output logic [CNT_W-1:0]     iteration_count,
	output logic [GRAY_W-1:0]    gray_level
);

	cmd_t    cmd;
	status_t status;

	mbet_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	mbet_datapath #(
		.FRAC_BITS(FRAC_BITS),
		.DIM_BITS (DIM_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.cmd            (cmd),
		.status         (status),
		.iteration_count(iteration_count),
		.gray_level     (gray_level)
	);

endmodule

/* tb/sv/mbet_escape_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_escape_checker
// Watches the register port, the pixel command channel and the result strobe
// of the escape-time evaluator. Each accepted pixel is evaluated here in
// fixed point against a local copy of the registers, the expected count and
// gray level are queued, and each strobed result is compared against the
// oldest queued entry. Mismatch and outstanding counts go back to the bench.
// ----------------------------------------------------------------------------
module mbet_escape_checker
	import mbet_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 start,
	input  logic                 busy,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	input  logic                 done,
	input  logic [CNT_W-1:0]     iteration_count,
	input  logic [GRAY_W-1:0]    gray_level,
	output int                   mismatches,
	output int                   pending
);

	localparam longint FX_ONE = longint'(1) << MBET_FRAC_BITS;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [GRAY_W-1:0] gray;
	} escape_t;

	escape_t          escape_q[$];
	logic [IMG_W-1:0] width_r;
	logic [IMG_W-1:0] height_r;
	logic [CNT_W-1:0] limit_r;
	int               errs;

	function automatic longint fx_floor_mul(input longint a, input longint b, input int sh);
		logic signed [127:0] pa;
		logic signed [127:0] pb;
		logic signed [127:0] p;
		pa = a;
		pb = b;
		p = (pa * pb) >>> sh;
		return longint'(p[63:0]);
	endfunction

	function automatic escape_t escape_time(
		input logic [PIX_W-1:0] px,
		input logic [PIX_W-1:0] py,
		input logic [IMG_W-1:0] wd,
		input logic [IMG_W-1:0] ht,
		input logic [CNT_W-1:0] lim
	);
		longint unsigned xs;
		longint unsigned ys;
		longint unsigned w;
		longint unsigned h;
		longint          cr;
		longint          ci;
		longint          zr;
		longint          zi;
		longint          zr2;
		longint          zi2;
		longint          t;
		int unsigned     n;
		bit              escaped;
		escape_t         r;
		xs = px;
		ys = py;
		w = (wd == '0) ? 1 : wd;
		h = (ht == '0) ? 1 : ht;
		if (3 * xs >= 5 * w) begin
			cr = 3 * FX_ONE;
		end else begin
			cr = longint'(((3 * xs) << MBET_FRAC_BITS) / w) - 2 * FX_ONE;
		end
		if (6 * ys >= 9 * h) begin
			ci = 3 * FX_ONE;
		end else begin
			ci = longint'(((3 * ys) << MBET_FRAC_BITS) / h) - (FX_ONE + FX_ONE / 2);
		end
		zr = 0;
		zi = 0;
		zr2 = 0;
		zi2 = 0;
		n = 0;
		escaped = 1'b0;
		while (!escaped && n < lim) begin
			t = zr2 - zi2 + cr;
			zi = fx_floor_mul(zr, zi, MBET_FRAC_BITS - 1) + ci;
			zr = t;
			if (zr > 2 * FX_ONE || zr < -2 * FX_ONE || zi > 2 * FX_ONE || zi < -2 * FX_ONE) begin
				escaped = 1'b1;
			end else begin
				zr2 = fx_floor_mul(zr, zr, MBET_FRAC_BITS);
				zi2 = fx_floor_mul(zi, zi, MBET_FRAC_BITS);
				escaped = (zr2 + zi2) > 4 * FX_ONE;
			end
			n++;
		end
		r.count = n[CNT_W-1:0];
		r.gray = (n < lim) ? GRAY_W'((n * 255) / lim) : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		escape_t want;
		escape_t got;
		if (!arst_n) begin
			width_r <= IMAGE_WIDTH_RST;
			height_r <= IMAGE_HEIGHT_RST;
			limit_r <= ITER_LIMIT_RST;
			escape_q.delete();
			errs = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH: width_r <= cfg_data[IMG_W-1:0];
					CFG_IMAGE_HEIGHT: height_r <= cfg_data[IMG_W-1:0];
					CFG_ITER_LIMIT: limit_r <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				got.count = iteration_count;
				got.gray = gray_level;
				if (escape_q.size() == 0) begin
					if (errs < 10) begin
						$display("%0t: unexpected result count %0d gray %0d",
							$time, got.count, got.gray);
					end
					errs++;
				end else begin
					want = escape_q.pop_front();
					if (got.count !== want.count || got.gray !== want.gray) begin
						if (errs < 10) begin
							$display("%0t: mismatch count exp %0d got %0d, gray exp %0d got %0d",
								$time, want.count, got.count, want.gray, got.gray);
						end
						errs++;
					end
				end
			end
			if (start && !busy) begin
				escape_q.push_back(escape_time(pixel_x, pixel_y, width_r, height_r, limit_r));
			end
			mismatches <= errs;
			pending <= escape_q.size();
		end
	end

endmodule

/* tb/sv/mandelbrot_escape_time_pixel_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_tb
// Drives pixel commands and register writes into the escape-time evaluator.
// A directed set covers image corners, points inside the set, clamped
// coordinates and zero or extreme register values; random phases follow with
// fresh register settings, mostly in-image pixels and random sender gaps.
// The checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_tb;
	import mbet_pkg::*;

	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 69;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [PIX_W-1:0]     pixel_x = '0;
	logic [PIX_W-1:0]     pixel_y = '0;
	logic                 done;
	logic [CNT_W-1:0]     iteration_count;
	logic [GRAY_W-1:0]    gray_level;
	int                   mismatches;
	int                   pending;
	int                   cycles = 0;
	bit                   gaps_on = 1'b0;

	mandelbrot_escape_time_pixel u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start           (start),
		.busy            (busy),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.done            (done),
		.iteration_count (iteration_count),
		.gray_level      (gray_level)
	);

	mbet_escape_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start           (start),
		.busy            (busy),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.done            (done),
		.iteration_count (iteration_count),
		.gray_level      (gray_level),
		.mismatches      (mismatches),
		.pending         (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic push_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		start <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	// drop start and hold until every item has come back
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
	endtask

	task automatic configure(input int unsigned w, input int unsigned h, input int unsigned lim);
		logic [2:0] pad;
		drain();
		pad = 3'($urandom);
		cfg_write <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= {pad, w[IMG_W-1:0]};
		@(negedge clk);
		pad = 3'($urandom);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= {pad, h[IMG_W-1:0]};
		@(negedge clk);
		cfg_index <= CFG_ITER_LIMIT;
		cfg_data <= lim[CNT_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 4096;
			3: return 8191;
			default: return $urandom_range(2, 4096);
		endcase
	endfunction

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned lim;
		int unsigned xspan;
		int unsigned yspan;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		gaps_on = 1'b1;

		push_pixel(12'd0, 12'd0);
		push_pixel(12'd4095, 12'd4095);
		push_pixel(12'd0, 12'd4095);
		push_pixel(12'd4095, 12'd0);
		push_pixel(12'd800, 12'd600);
		push_pixel(12'd1066, 12'd600);
		push_pixel(12'd2666, 12'd1799);
		push_pixel(12'd2667, 12'd1800);
		push_pixel(12'd2048, 12'd2048);
		push_pixel(12'd2047, 12'd2047);

		configure(0, 0, 0);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd4095, 12'd4095);
		configure(0, 0, 5);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd1, 12'd1);
		configure(8191, 4096, 65535);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd4095, 12'd2048);
		configure(1, 1, 1);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd1, 12'd1);
		configure(4096, 4096, 255);
		push_pixel(12'd2730, 12'd2048);
		push_pixel(12'd3000, 12'd1000);

		for (int p = 0; p < RAND_PHASES; p++) begin
			w = pick_dim();
			h = pick_dim();
			case ($urandom_range(0, 9))
				0: lim = 0;
				1: lim = 1;
				2: lim = $urandom_range(200, 1000);
				default: lim = $urandom_range(2, 64);
			endcase
			configure(w, h, lim);
			gaps_on = (p < RAND_PHASES - 1);
			xspan = (w == 0) ? 1 : ((w > 4096) ? 4096 : w);
			yspan = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						x = PIX_W'($urandom);
						y = PIX_W'($urandom);
					end
					3, 4: begin
						x = $urandom_range(0, 1) ? '1 : '0;
						y = $urandom_range(0, 1) ? '1 : '0;
					end
					default: begin
						x = PIX_W'($urandom_range(0, xspan - 1));
						y = PIX_W'($urandom_range(0, yspan - 1));
					end
				endcase
				push_pixel(x, y);
				if (gaps_on && $urandom_range(0, 49) == 0) begin
					drain();
				end
			end
		end

		drain();
		repeat (300) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* mandelbrot_escape_time_pixel.f */
hdl/mbet_pkg.sv
hdl/mbet_div.sv
hdl/mbet_datapath.sv
hdl/mbet_ctrl.sv
hdl/mandelbrot_escape_time_pixel.sv
tb/sv/mbet_escape_checker.sv
tb/sv/mandelbrot_escape_time_pixel_tb.sv
